@@ rtl/core/rdhr_pkg.sv @@
// Package for the rain delta history ring: widths, depth, register map and the
// access decision record shared by the access logic and the top level.
// No dependencies.
package rdhr_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned Depth     = 256;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = 9;   // record_count and distance fields
  localparam int unsigned IdxW      = CntW + 1;
  localparam int unsigned InTdataW  = 48;  // rain_total + distance, byte padded
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [ApbAddrW-1:0] RegRecordCount   = 3'd0;
  localparam logic [CntW-1:0]     RecordCountReset = 9'd256;

  typedef enum logic {
    ModeSave = 1'b0,
    ModeRead = 1'b1
  } mode_e;

  // What one accepted beat does to the ring and what it reports.
  typedef struct packed {
    logic [AddrW-1:0] addr;     // ring entry written (save) or read (record)
    logic             pending;  // read of the pending increase
    logic             oor;      // distance beyond the record count
    logic [DataW-1:0] amount;   // save data, or the pending increase
    logic [AddrW-1:0] wp_next;  // write pointer after a save
  } access_t;

endpackage

@@ rtl/core/rain_delta_history_ring_top.sv @@
// Top level of the rain delta history ring: stream ports, APB register,
// ring state and result pipeline. Depends on rdhr_pkg, rdhr_ram, rdhr_access.
//
//   Channel   Direction  Carries
//   s_axis    in         tdata = rain_total, distance; tuser = mode
//   m_axis    out        tdata = rain_amount; tuser = out_of_range
//   apb       in/out     record_count at byte address 0
//
// One beat is accepted per cycle while s_axis_tready is high. A read's result
// passes through the registered RAM read, then the output register, to m_axis.
// Saves produce no result. Reset clears the control state at once; the ring
// needs no clearing pass because one valid flag per entry makes never-written
// entries read as zero. A stalled output holds the pipeline, so s_axis_tready
// drops only while the output register is full and not taken.
module rain_delta_history_ring_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream; tdata: [31:0] rain_total, [40:32] distance, [47:41] zero
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rdhr_pkg::InTdataW-1:0]    s_axis_tdata,
  input  logic [0:0]                       s_axis_tuser,  // [0] mode
  // Result stream; tdata: [31:0] rain_amount
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rdhr_pkg::DataW-1:0]       m_axis_tdata,
  output logic [0:0]                       m_axis_tuser,  // [0] out_of_range
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rdhr_pkg::ApbAddrW-1:0]    paddr,
  input  logic [rdhr_pkg::ApbDataW-1:0]    pwdata,
  output logic [rdhr_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);

  // Configuration register.
  logic [rdhr_pkg::CntW-1:0] record_count_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_count_q <= rdhr_pkg::RecordCountReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == rdhr_pkg::RegRecordCount)) begin
      record_count_q <= pwdata[rdhr_pkg::CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == rdhr_pkg::RegRecordCount) begin
      prdata = rdhr_pkg::ApbDataW'(record_count_q);
    end
  end

  // Input fields.
  logic [rdhr_pkg::DataW-1:0] rain_total;
  logic [rdhr_pkg::CntW-1:0]  distance;
  rdhr_pkg::mode_e            mode;

  assign rain_total = s_axis_tdata[rdhr_pkg::DataW-1:0];
  assign distance   = s_axis_tdata[rdhr_pkg::DataW +: rdhr_pkg::CntW];
  assign mode       = rdhr_pkg::mode_e'(s_axis_tuser[0]);

  // Ring state.
  logic [rdhr_pkg::AddrW-1:0] wp_q;
  logic [rdhr_pkg::DataW-1:0] last_total_q;
  logic                       started_q;
  logic [rdhr_pkg::Depth-1:0] valid_q;

  // Pipeline: stage 1 waits on the RAM read, then the output register.
  logic                       s1_valid_q;
  logic                       s1_pending_q;
  logic                       s1_oor_q;
  logic                       s1_vld_q;
  logic [rdhr_pkg::DataW-1:0] s1_amount_q;
  logic                       out_valid_q;
  logic [rdhr_pkg::DataW-1:0] out_amount_q;
  logic                       out_oor_q;

  logic                       s_fire;
  logic                       save;
  logic                       s1_adv;
  logic [rdhr_pkg::DataW-1:0] ram_rdata;
  logic [rdhr_pkg::DataW-1:0] s1_result;
  rdhr_pkg::access_t          acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign save          = (mode == rdhr_pkg::ModeSave);

  rdhr_access u_access (
    .save_i         (save),
    .rain_total_i   (rain_total),
    .distance_i     (distance),
    .record_count_i (record_count_q),
    .wp_i           (wp_q),
    .last_total_i   (last_total_q),
    .started_i      (started_q),
    .acc_o          (acc)
  );

  // The read data register only moves on a read, so it holds while stage 1
  // is stalled (no beat is accepted then).
  rdhr_ram #(
    .Width (rdhr_pkg::DataW),
    .Depth (rdhr_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (s_fire),
    .we_i    (save),
    .addr_i  (acc.addr),
    .wdata_i (acc.amount),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      last_total_q <= '0;
      started_q    <= 1'b0;
      valid_q      <= '0;
    end else if (s_fire && save) begin
      wp_q             <= acc.wp_next;
      last_total_q     <= rain_total;
      started_q        <= 1'b1;
      valid_q[acc.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_fire) begin
      s1_valid_q <= !save;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && !save) begin
      s1_pending_q <= acc.pending;
      s1_oor_q     <= acc.oor;
      s1_vld_q     <= valid_q[acc.addr];
      s1_amount_q  <= acc.amount;
    end
  end

  always_comb begin
    if (s1_pending_q) begin
      s1_result = s1_amount_q;
    end else if (s1_oor_q || !s1_vld_q) begin
      s1_result = '0;
    end else begin
      s1_result = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_amount_q <= s1_result;
      out_oor_q    <= s1_oor_q && !s1_pending_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_amount_q;
  assign m_axis_tuser[0] = out_oor_q;

`ifndef SYNTHESIS
  // A save never puts a beat into the result pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && save) |=> !s1_valid_q)
    else $error("save produced a pending result");

  // An out-of-range result always carries a zero amount.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("out-of-range result with nonzero amount");

  // Input backpressure only comes from a full, untaken output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // After any save the ring counts as started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && save) |=> started_q)
    else $error("save did not mark the ring started");
`endif

endmodule

@@ rtl/core/rdhr_ram.sv @@
// Generic single-port RAM with a registered read port.
// No dependencies.
module rdhr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rdhr_access.sv @@
// Decides the ring access of one beat: entry address, increase, read range and
// the next write pointer. Depends on rdhr_pkg.
module rdhr_access (
  input  logic                          save_i,
  input  logic [rdhr_pkg::DataW-1:0]    rain_total_i,
  input  logic [rdhr_pkg::CntW-1:0]     distance_i,
  input  logic [rdhr_pkg::CntW-1:0]     record_count_i,
  input  logic [rdhr_pkg::AddrW-1:0]    wp_i,
  input  logic [rdhr_pkg::DataW-1:0]    last_total_i,
  input  logic                          started_i,
  output rdhr_pkg::access_t             acc_o
);

  logic [rdhr_pkg::CntW-1:0]  cnt;
  logic [rdhr_pkg::DataW-1:0] inc;
  logic [rdhr_pkg::CntW-1:0]  wp_inc;
  logic [rdhr_pkg::IdxW-1:0]  wp_x;
  logic [rdhr_pkg::IdxW-1:0]  dist_x;
  logic [rdhr_pkg::IdxW-1:0]  idx;

  always_comb begin
    // Clamp the configured count into 1..Depth.
    if (record_count_i == '0) begin
      cnt = rdhr_pkg::CntW'(1);
    end else if (record_count_i > rdhr_pkg::CntW'(rdhr_pkg::Depth)) begin
      cnt = rdhr_pkg::CntW'(rdhr_pkg::Depth);
    end else begin
      cnt = record_count_i;
    end

    // A fallen total means the gauge counter restarted: take it raw.
    inc = (rain_total_i < last_total_i) ? rain_total_i : (rain_total_i - last_total_i);

    wp_inc = {1'b0, wp_i} + rdhr_pkg::CntW'(1);

    wp_x   = rdhr_pkg::IdxW'(wp_i);
    dist_x = {1'b0, distance_i};
    if (dist_x <= wp_x) begin
      idx = wp_x - dist_x;
    end else begin
      idx = {1'b0, cnt} + wp_x - dist_x;
    end
    if (idx >= rdhr_pkg::IdxW'(rdhr_pkg::Depth)) begin
      idx = '0;
    end

    acc_o.addr    = save_i ? wp_i : idx[rdhr_pkg::AddrW-1:0];
    acc_o.pending = (distance_i == '0);
    acc_o.oor     = (distance_i > cnt);
    acc_o.amount  = (save_i && !started_i) ? '0 : inc;
    acc_o.wp_next = (wp_inc >= cnt) ? '0 : wp_inc[rdhr_pkg::AddrW-1:0];
  end

endmodule
